// ===== design/avcc_pkg.sv =====
// Package for the length-prefixed to start-code video stream converter.
// Holds the transaction structs, phase and error codes and shared constants.
// No dependencies.
package avcc_pkg;

    localparam int LEN_BYTES      = 4;
    localparam int START_CODE_LEN = 4;
    localparam int CMD_DEPTH      = 4;
    localparam logic [4:0] UNIT_TYPE_MASK = 5'h1f;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_PAY  = 2'd1,
        PH_DROP = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNC_LEN = 2'd1,
        ERR_NEG_LEN   = 2'd2,
        ERR_TRUNC_PAY = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       start_of_unit;
        logic       first_payload;
        logic [4:0] unit_type;
        logic       packet_done;
        err_code_t  error_code;
        logic       last_of_run;
    } out_item_t;

    // One queued command: either a single finished result, or a start code
    // that the back end expands into four results.
    typedef struct packed {
        logic      is_start;
        out_item_t item;
    } cmd_t;

endpackage

// ===== design/avcc_front.sv =====
// Front end: accepts packet bytes, tracks the length/payload phase and
// writes one command per byte that produces output. Depends on avcc_pkg.
module avcc_front
    import avcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t packet_byte,
    output logic     cmd_push,
    output cmd_t     cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic        first_reg, first_next;

    logic [31:0] len_word;
    logic        last_len_byte;
    logic        eop;
    logic        rem_is_one;

    assign len_word      = {rem_reg[23:0], packet_byte.data_byte};
    assign last_len_byte = (cnt_reg == 2'(LEN_BYTES - 1));
    assign eop           = packet_byte.end_of_packet;
    assign rem_is_one    = (rem_reg == 32'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            first_reg <= first_next;
        end
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        first_next = first_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    rem_next = len_word;
                    if (!last_len_byte)
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        if (eop)
                        begin
                            cnt_next = '0;
                            rem_next = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (len_word[31])
                        begin
                            rem_next = '0;
                            if (!eop)
                                phase_next = PH_DROP;
                        end
                        else if (eop || len_word == 32'd0)
                        begin
                            rem_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAY;
                            first_next = 1'b1;
                        end
                    end
                end
                PH_PAY:
                begin
                    first_next = 1'b0;
                    rem_next   = rem_reg - 32'd1;
                    if (rem_is_one || eop)
                    begin
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                        rem_next   = '0;
                    end
                end
                default:
                begin
                    if (eop)
                    begin
                        phase_next = PH_LEN;
                        cnt_next   = '0;
                        rem_next   = '0;
                        first_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Command generation.
    always_comb
    begin
        cmd_push = 1'b0;
        cmd      = '0;
        cmd.item.last_of_run = 1'b1;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (!last_len_byte)
                    begin
                        if (eop)
                        begin
                            cmd_push = 1'b1;
                            cmd.item.packet_done = 1'b1;
                            cmd.item.error_code  = ERR_TRUNC_LEN;
                        end
                    end
                    else if (len_word[31])
                    begin
                        cmd_push = 1'b1;
                        cmd.item.packet_done = eop;
                        cmd.item.error_code  = ERR_NEG_LEN;
                    end
                    else if (eop && len_word != 32'd0)
                    begin
                        cmd_push = 1'b1;
                        cmd.item.packet_done = 1'b1;
                        cmd.item.error_code  = ERR_TRUNC_PAY;
                    end
                    else
                    begin
                        cmd_push = 1'b1;
                        cmd.is_start = 1'b1;
                        cmd.item.packet_done = eop;
                    end
                end
                PH_PAY:
                begin
                    cmd_push = 1'b1;
                    cmd.item.out_byte      = packet_byte.data_byte;
                    cmd.item.has_byte      = 1'b1;
                    cmd.item.first_payload = first_reg;
                    cmd.item.unit_type     = first_reg ?
                        (packet_byte.data_byte[4:0] & UNIT_TYPE_MASK) : 5'd0;
                    cmd.item.packet_done   = eop;
                    cmd.item.error_code    = (eop && !rem_is_one) ? ERR_TRUNC_PAY
                                                                  : ERR_NONE;
                end
                default:
                begin
                    if (eop)
                    begin
                        cmd_push = 1'b1;
                        cmd.item.packet_done = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/avcc_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on avcc_pkg for the command type.
module avcc_cmd_fifo
    import avcc_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue count exceeds depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count did not rise on a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("command queue pointers differ while empty");

endmodule

// ===== design/avcc_back.sv =====
// Back end: expands queued commands into results and holds the result
// register seen on the output ports. Depends on avcc_pkg.
module avcc_back
    import avcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd_head,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int IDX_W = $clog2(START_CODE_LEN);

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             can_load;
    logic             sc_last;

    assign empty    = !out_valid_reg;
    assign result   = out_item_reg;
    assign can_load = !out_valid_reg || pop;
    assign sc_last  = (idx_reg == IDX_W'(START_CODE_LEN - 1));

    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        out_item_next  = out_item_reg;
        idx_next       = idx_reg;
        cmd_pop        = 1'b0;
        if (can_load && !cmd_empty)
        begin
            out_valid_next = 1'b1;
            if (cmd_head.is_start)
            begin
                out_item_next               = '0;
                out_item_next.out_byte      = sc_last ? 8'h01 : 8'h00;
                out_item_next.has_byte      = 1'b1;
                out_item_next.start_of_unit = (idx_reg == '0);
                out_item_next.packet_done   = sc_last && cmd_head.item.packet_done;
                out_item_next.last_of_run   = sc_last;
                if (sc_last)
                begin
                    idx_next = '0;
                    cmd_pop  = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            else
            begin
                out_item_next = cmd_head.item;
                cmd_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    a_idx_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (!cmd_empty && cmd_head.is_start))
        else $error("start code in progress without a start command at the head");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> out_valid_reg && out_item_reg.last_of_run)
        else $error("command retired without its last result");

    a_sc_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.start_of_unit) |-> out_item_reg.has_byte
            && out_item_reg.out_byte == 8'h00)
        else $error("start-of-unit result is not a start code byte");

endmodule

// ===== design/avcc_to_annexb_nal_converter_unit.sv =====
// Top level of the length-prefixed to start-code video stream converter.
// Instantiates avcc_front, avcc_cmd_fifo and avcc_back; uses avcc_pkg.
//
// Usage:
//   Input channel: packet_byte carries one byte of a packet and its
//   end-of-packet flag; a transaction takes place when push is high and
//   full is low. Each NAL unit is a 4-byte big-endian length and payload.
//   Result channel: while empty is low, result holds the oldest result;
//   a transaction takes place when pop is high and empty is low.
//   A non-negative length field becomes the start code 00 00 00 01, unless
//   nonzero at packet end; payload passes through; errors go to error_code.
// Path: each command is written into the command queue and then loaded into
//   the result register, if the result side is not stalled.
// Throughput: one input byte per cycle while full is low; the back end gives
//   one result per cycle while results are taken; the command queue
//   (CMD_DEPTH entries) absorbs the burst of four results of a start code.
// Reset: rst_n clears the phase to length gathering and empties the queue
//   and the result register. When the receiver stalls, the result holds,
//   the queue fills and full rises until results are taken again.
module avcc_to_annexb_nal_converter_unit
    import avcc_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  packet_byte,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic cmd_push, cmd_pop, cmd_empty, accept;
    cmd_t cmd, cmd_head;

    assign accept = push && !full;

    avcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .packet_byte (packet_byte),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    avcc_cmd_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .full      (full),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .empty     (cmd_empty)
    );

    avcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_head  (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ===== test/avcc_to_annexb_nal_converter_unit_tb.sv =====
// Self-checking testbench for the length-prefixed to start-code stream converter.
// Predicts every result from the accepted input bytes and compares each field on the
// queue-style result port. Depends on avcc_pkg and avcc_to_annexb_nal_converter_unit.
module avcc_to_annexb_nal_converter_unit_tb;
    import avcc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  packet_byte;
    logic      empty;
    logic      pop;
    out_item_t result;

    // Parser state that mirrors the block.
    phase_t      cur_phase;
    logic [1:0]  len_count;
    logic [31:0] remaining;
    logic        first_pending;

    out_item_t expected_stream[$];
    int        mismatches = 0;
    int        bytes_sent = 0;
    int        tx_idle_pct = 35;
    int        rx_idle_pct = 35;
    int        hold_request = 0;
    int        quiet_cycles = 0;

    avcc_to_annexb_nal_converter_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .packet_byte (packet_byte),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic out_item_t stream_result(logic [7:0] b, logic has, logic sou,
                                                logic first, logic [4:0] utype,
                                                logic done, err_code_t err);
        out_item_t r;
        r = '0;
        r.out_byte      = b;
        r.has_byte      = has;
        r.start_of_unit = sou;
        r.first_payload = first;
        r.unit_type     = utype;
        r.packet_done   = done;
        r.error_code    = err;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Appends one predicted result at the tail of the expected stream.
    function automatic void expect_result(out_item_t r);
        expected_stream.insert(expected_stream.size(), r);
    endfunction

    function automatic void clear_parser();
        cur_phase     = PH_LEN;
        len_count     = 2'd0;
        remaining     = 32'd0;
        first_pending = 1'b0;
    endfunction

    // Works out the results that one accepted byte causes and queues them.
    function automatic void convert_byte(in_item_t it);
        logic [7:0] b;
        logic       eop;
        logic       first;
        logic [4:0] utype;
        int         prior;
        b     = it.data_byte;
        eop   = it.end_of_packet;
        prior = expected_stream.size();
        case (cur_phase)
            PH_LEN:
            begin
                remaining = {remaining[23:0], b};
                if (len_count != 2'd3)
                begin
                    len_count = len_count + 2'd1;
                    if (eop)
                    begin
                        expect_result(stream_result(8'h00, 0, 0, 0, 5'd0, 1, ERR_TRUNC_LEN));
                        clear_parser();
                    end
                end
                else
                begin
                    len_count = 2'd0;
                    if (remaining[31])
                    begin
                        expect_result(stream_result(8'h00, 0, 0, 0, 5'd0, eop, ERR_NEG_LEN));
                        if (eop)
                            clear_parser();
                        else
                        begin
                            cur_phase = PH_DROP;
                            remaining = 32'd0;
                        end
                    end
                    else if (eop && remaining != 32'd0)
                    begin
                        expect_result(stream_result(8'h00, 0, 0, 0, 5'd0, 1, ERR_TRUNC_PAY));
                        clear_parser();
                    end
                    else
                    begin
                        expect_result(stream_result(8'h00, 1, 1, 0, 5'd0, 0, ERR_NONE));
                        expect_result(stream_result(8'h00, 1, 0, 0, 5'd0, 0, ERR_NONE));
                        expect_result(stream_result(8'h00, 1, 0, 0, 5'd0, 0, ERR_NONE));
                        expect_result(stream_result(8'h01, 1, 0, 0, 5'd0, eop, ERR_NONE));
                        if (remaining == 32'd0)
                            clear_parser();
                        else
                        begin
                            cur_phase     = PH_PAY;
                            first_pending = 1'b1;
                        end
                    end
                end
            end
            PH_PAY:
            begin
                first         = first_pending;
                utype         = first ? (b[4:0] & UNIT_TYPE_MASK) : 5'd0;
                first_pending = 1'b0;
                remaining     = remaining - 32'd1;
                if (remaining == 32'd0)
                begin
                    expect_result(stream_result(b, 1, 0, first, utype, eop, ERR_NONE));
                    clear_parser();
                end
                else if (eop)
                begin
                    expect_result(stream_result(b, 1, 0, first, utype, 1, ERR_TRUNC_PAY));
                    clear_parser();
                end
                else
                    expect_result(stream_result(b, 1, 0, first, utype, 0, ERR_NONE));
            end
            default:
            begin
                if (eop)
                begin
                    expect_result(stream_result(8'h00, 0, 0, 0, 5'd0, 1, ERR_NONE));
                    clear_parser();
                end
            end
        endcase
        if (expected_stream.size() > prior)
            expected_stream[expected_stream.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eop);
        in_item_t it;
        it.data_byte     = b;
        it.end_of_packet = eop;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        packet_byte <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        convert_byte(it);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] pkt[$]);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Mostly well-formed packets with random payloads; the rest are cut short,
    // carry a negative length, or are plain noise.
    task automatic send_random_packet();
        logic [7:0]  pkt[$];
        logic [31:0] ulen;
        int          units;
        int          len;
        int          kind;
        int          cut;
        units = $urandom_range(1, 3);
        kind  = $urandom_range(99);
        for (int u = 0; u < units; u++)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
            ulen = len;
            if (kind < 6 && u == units - 1)
                ulen = {1'b1, 31'($urandom)};
            pkt.insert(pkt.size(), ulen[31:24]);
            pkt.insert(pkt.size(), ulen[23:16]);
            pkt.insert(pkt.size(), ulen[15:8]);
            pkt.insert(pkt.size(), ulen[7:0]);
            for (int i = 0; i < len; i++)
                pkt.insert(pkt.size(), 8'($urandom_range(255)));
        end
        if (kind >= 6 && kind < 14)
        begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        else if (kind >= 14 && kind < 18)
        begin
            pkt.delete();
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                pkt.insert(pkt.size(), 8'($urandom_range(255)));
        end
        send_packet(pkt);
    endtask

    task automatic test_directed_cases();
        logic [7:0] pkt[$];
        // Zero-length unit, a one-byte unit of type 31, then a zero length ending the packet.
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff,
                8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(pkt);
        // Largest positive length, packet ends inside the payload on a type-0 byte.
        pkt = '{8'h7f, 8'hff, 8'hff, 8'hff, 8'he0};
        send_packet(pkt);
        // Packet ends inside the length field.
        pkt = '{8'hab};
        send_packet(pkt);
        // Negative length, then input is dropped until the packet ends.
        pkt = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h5a};
        send_packet(pkt);
        // Negative length on the packet's last byte.
        pkt = '{8'hff, 8'hff, 8'hff, 8'hff};
        send_packet(pkt);
        // Nonzero length on the packet's last byte gives no start code.
        pkt = '{8'h00, 8'h00, 8'h00, 8'h05};
        send_packet(pkt);
    endtask

    task automatic test_random_traffic(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
            send_random_packet();
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(n);
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    // The receiver stops taking results while the sender keeps pushing, so the
    // command queue fills and full must hold the input back.
    task automatic test_result_hold_off(input int n);
        tx_idle_pct  = 0;
        hold_request = HOLD_OFF_CYCLES;
        test_random_traffic(n);
        tx_idle_pct  = 35;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        push        <= 1'b0;
        packet_byte <= '0;
        clear_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(200);
        test_back_to_back(100);
        test_result_hold_off(60);
        test_random_traffic(450 - bytes_sent);
        push <= 1'b0;

        while (expected_stream.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random pop, with a long hold-off when a test requests one.
    initial
    begin : result_drain
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_stream.size() == 0)
            begin
                $error("result transaction with nothing expected: 0x%0h", result);
                mismatches++;
            end
            else
            begin
                want = expected_stream.pop_front();
                check_field("out_byte", want.out_byte, result.out_byte);
                check_field("has_byte", want.has_byte, result.has_byte);
                check_field("start_of_unit", want.start_of_unit, result.start_of_unit);
                check_field("first_payload", want.first_payload, result.first_payload);
                check_field("unit_type", want.unit_type, result.unit_type);
                check_field("packet_done", want.packet_done, result.packet_done);
                check_field("error_code", want.error_code, result.error_code);
                check_field("last_of_run", want.last_of_run, result.last_of_run);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
